// ===== rtl/core/thumb_instruction_classifier_macros.svh =====
// Assertion macros for the Thumb classifier.
// All checks sample on i_clk and are off while i_rst_n is low.
`ifndef THUMB_INSTRUCTION_CLASSIFIER_MACROS_SVH
`define THUMB_INSTRUCTION_CLASSIFIER_MACROS_SVH

// Consequent must hold in the cycle the antecedent holds.
`define TIC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Expression must never be true.
`define TIC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/core/thumb_cls_pkg.sv =====
package thumb_cls_pkg;

    localparam int unsigned HALF_W = 16;
    localparam int unsigned ID_W   = 7;

    typedef logic [HALF_W-1:0] t_half;
    typedef logic [ID_W-1:0]   t_id;

    localparam t_id ID_UNDEFINED = 7'd0;
    localparam t_id ID_LSL1  = 7'd1;
    localparam t_id ID_LSR1  = 7'd2;
    localparam t_id ID_ASR1  = 7'd3;
    localparam t_id ID_ADD1  = 7'd4;
    localparam t_id ID_ADD3  = 7'd5;
    localparam t_id ID_SUB1  = 7'd6;
    localparam t_id ID_SUB3  = 7'd7;
    localparam t_id ID_MOV2  = 7'd8;
    localparam t_id ID_ADD2  = 7'd9;
    localparam t_id ID_CMP1  = 7'd10;
    localparam t_id ID_MOV1  = 7'd11;
    localparam t_id ID_SUB2  = 7'd12;
    localparam t_id ID_LDR3  = 7'd13;
    localparam t_id ID_STR2  = 7'd14;
    localparam t_id ID_STRH2 = 7'd15;
    localparam t_id ID_STRB2 = 7'd16;
    localparam t_id ID_LDRSB = 7'd17;
    localparam t_id ID_LDR2  = 7'd18;
    localparam t_id ID_LDRH2 = 7'd19;
    localparam t_id ID_LDRB2 = 7'd20;
    localparam t_id ID_LDRSH = 7'd21;
    localparam t_id ID_ADC   = 7'd22;
    localparam t_id ID_ADD4  = 7'd23;
    localparam t_id ID_AND   = 7'd24;
    localparam t_id ID_ASR2  = 7'd25;
    localparam t_id ID_BIC   = 7'd26;
    localparam t_id ID_BLX2  = 7'd27;
    localparam t_id ID_BX    = 7'd28;
    localparam t_id ID_CMN   = 7'd29;
    localparam t_id ID_CMP2  = 7'd30;
    localparam t_id ID_CMP3  = 7'd31;
    localparam t_id ID_EOR   = 7'd32;
    localparam t_id ID_LSL2  = 7'd33;
    localparam t_id ID_LSR2  = 7'd34;
    localparam t_id ID_MOV3  = 7'd35;
    localparam t_id ID_MUL   = 7'd36;
    localparam t_id ID_MVN   = 7'd37;
    localparam t_id ID_NEG   = 7'd38;
    localparam t_id ID_ORR   = 7'd39;
    localparam t_id ID_ROR   = 7'd40;
    localparam t_id ID_SBC   = 7'd41;
    localparam t_id ID_TST   = 7'd42;
    localparam t_id ID_STR1  = 7'd43;
    localparam t_id ID_LDR1  = 7'd44;
    localparam t_id ID_STRB1 = 7'd45;
    localparam t_id ID_LDRB1 = 7'd46;
    localparam t_id ID_STRH1 = 7'd47;
    localparam t_id ID_LDRH1 = 7'd48;
    localparam t_id ID_STR3  = 7'd49;
    localparam t_id ID_LDR4  = 7'd50;
    localparam t_id ID_ADD5  = 7'd51;
    localparam t_id ID_ADD6  = 7'd52;
    localparam t_id ID_ADD7  = 7'd53;
    localparam t_id ID_SUB4  = 7'd54;
    localparam t_id ID_PUSH  = 7'd55;
    localparam t_id ID_BKPT  = 7'd56;
    localparam t_id ID_POP   = 7'd57;
    localparam t_id ID_STMIA = 7'd58;
    localparam t_id ID_LDMIA = 7'd59;
    localparam t_id ID_SWI   = 7'd60;
    localparam t_id ID_B1    = 7'd61;
    localparam t_id ID_B2    = 7'd62;
    localparam t_id ID_BLX1  = 7'd63;
    localparam t_id ID_BL    = 7'd64;

    // Major groups, bits 15..13.
    localparam logic [2:0] GRP_SHIFT   = 3'b000;
    localparam logic [2:0] GRP_IMM     = 3'b001;
    localparam logic [2:0] GRP_REG     = 3'b010;
    localparam logic [2:0] GRP_LS_WB   = 3'b011;
    localparam logic [2:0] GRP_LS_HSP  = 3'b100;
    localparam logic [2:0] GRP_MISC    = 3'b101;
    localparam logic [2:0] GRP_MULT_BR = 3'b110;
    localparam logic [2:0] GRP_BRANCH  = 3'b111;

    localparam logic [4:0] SWI_ROW = 5'b11111;

    // Data processing and hi-register ops, indexed by bits 10..6.
    function automatic t_id dataproc_id(input logic [4:0] sel);
        t_id id;
        unique case (sel)
            5'd0:  id = ID_AND;
            5'd1:  id = ID_EOR;
            5'd2:  id = ID_LSL2;
            5'd3:  id = ID_LSR2;
            5'd4:  id = ID_ASR2;
            5'd5:  id = ID_ADC;
            5'd6:  id = ID_SBC;
            5'd7:  id = ID_ROR;
            5'd8:  id = ID_TST;
            5'd9:  id = ID_NEG;
            5'd10: id = ID_CMP2;
            5'd11: id = ID_CMN;
            5'd12: id = ID_ORR;
            5'd13: id = ID_MUL;
            5'd14: id = ID_BIC;
            5'd15: id = ID_MVN;
            5'd16, 5'd17, 5'd18, 5'd19: id = ID_ADD4;
            5'd20, 5'd21, 5'd22, 5'd23: id = ID_CMP3;
            5'd24, 5'd25, 5'd26, 5'd27: id = ID_MOV3;
            5'd28, 5'd29: id = ID_BX;
            default: id = ID_BLX2;
        endcase
        return id;
    endfunction

    // Register-offset load/store, indexed by bits 11..9.
    function automatic t_id regofs_id(input logic [2:0] sel);
        t_id id;
        unique case (sel)
            3'd0: id = ID_STR2;
            3'd1: id = ID_STRH2;
            3'd2: id = ID_STRB2;
            3'd3: id = ID_LDRSB;
            3'd4: id = ID_LDR2;
            3'd5: id = ID_LDRH2;
            3'd6: id = ID_LDRB2;
            default: id = ID_LDRSH;
        endcase
        return id;
    endfunction

    function automatic t_id classify(input t_half h);
        t_id        id;
        logic [1:0] op;
        op = h[12:11];
        unique case (h[15:13])
            GRP_SHIFT: begin
                unique case (op)
                    2'd0: id = ID_LSL1;
                    2'd1: id = ID_LSR1;
                    2'd2: id = ID_ASR1;
                    default: begin
                        unique case (h[10:9])
                            2'd0: id = ID_ADD3;
                            2'd1: id = ID_SUB3;
                            2'd2: id = ID_ADD1;
                            default: id = ID_SUB1;
                        endcase
                    end
                endcase
            end
            GRP_IMM: begin
                unique case (op)
                    2'd0: id = ID_MOV1;
                    2'd1: id = ID_CMP1;
                    2'd2: id = ID_ADD2;
                    default: id = ID_SUB2;
                endcase
            end
            GRP_REG: begin
                priority if (op == 2'd1) begin
                    id = ID_LDR3;
                end else if (op[1]) begin
                    id = regofs_id(h[11:9]);
                end else begin
                    id = dataproc_id(h[10:6]);
                end
            end
            GRP_LS_WB: begin
                unique case (op)
                    2'd0: id = ID_STR1;
                    2'd1: id = ID_LDR1;
                    2'd2: id = ID_STRB1;
                    default: id = ID_LDRB1;
                endcase
            end
            GRP_LS_HSP: begin
                unique case (op)
                    2'd0: id = ID_STRH1;
                    2'd1: id = ID_LDRH1;
                    2'd2: id = ID_STR3;
                    default: id = ID_LDR4;
                endcase
            end
            GRP_MISC: begin
                unique case (op)
                    2'd0: id = ID_ADD5;
                    2'd1: id = ID_ADD6;
                    2'd2: begin
                        priority if (h[10:7] == 4'd0) begin
                            id = ID_ADD7;
                        end else if (h[10:7] == 4'd1) begin
                            id = ID_SUB4;
                        end else if (h[10:9] == 2'd2) begin
                            id = ID_PUSH;
                        end else begin
                            id = ID_UNDEFINED;
                        end
                    end
                    default: begin
                        priority if (h[10:8] == 3'd6) begin
                            id = ID_BKPT;
                        end else if (h[10:9] == 2'd2) begin
                            id = ID_POP;
                        end else begin
                            id = ID_UNDEFINED;
                        end
                    end
                endcase
            end
            GRP_MULT_BR: begin
                priority if (op == 2'd0) begin
                    id = ID_STMIA;
                end else if (op == 2'd1) begin
                    id = ID_LDMIA;
                end else if (h[12:8] == SWI_ROW) begin
                    id = ID_SWI;
                end else begin
                    id = ID_B1;
                end
            end
            default: begin
                unique case (op)
                    2'd0: id = ID_B2;
                    2'd1: id = ID_BLX1;
                    default: id = ID_BL;
                endcase
            end
        endcase
        return id;
    endfunction

endpackage

// ===== rtl/core/thumb_instruction_classifier.sv =====
// Thumb instruction classifier: takes one 16-bit Thumb halfword per clock and
// returns a 7-bit instruction identifier (0 = undefined, 1..64 = form). busy
// never rises, so a new word may be started in every cycle. Each word goes
// through the input register, then the decode, then the result register.
// The result is shown on o_instr_id for one cycle only, marked by o_valid;
// there is no way to hold it, so capture it on that edge. Results leave in
// the order the words went in. Identifier 8 (MOV2) is never produced; the
// undefined conditional row 11110 in group 110 reads as B1, and the BLX
// prefix row 10 in group 111 reads as BL.
`include "thumb_instruction_classifier_macros.svh"

module thumb_instruction_classifier (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  thumb_cls_pkg::t_half i_instr_halfword,
    output logic                 o_valid,
    output thumb_cls_pkg::t_id   o_instr_id
);
    import thumb_cls_pkg::*;

    logic  r_in_valid;
    t_half r_half;
    logic  r_out_valid;
    t_id   r_id;
    t_id   n_id;

    // Never stall the sender: every stage advances every cycle.
    assign busy = 1'b0;

    // Input stage: capture the word on each start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_half <= i_instr_halfword;
        end
    end

    // Decode: group from bits 15..13, then the nested field tests.
    always_comb begin
        n_id = classify(r_half);
    end

    // Result stage: the strobe follows the input stage's strobe in the next cycle; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_id <= n_id;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_instr_id = r_id;

    // A result appears only where a start has passed through the input and result registers.
    `TIC_ASSERT_IMP(a_valid_follows_start, o_valid, $past(start, 2), "result without start")
    // MOV2 is unreachable by construction of group 000.
    `TIC_ASSERT_NEVER(a_no_mov2, o_valid && (o_instr_id == ID_MOV2), "MOV2 produced")
    // Only the miscellaneous group 1011 can decode as undefined.
    `TIC_ASSERT_IMP(a_undef_only_misc, o_valid && (o_instr_id == ID_UNDEFINED),
        ($past(i_instr_halfword[15:12], 2) == {GRP_MISC, 1'b1}),
        "undefined outside group 1011")

endmodule
